[rtl/utf8_run_replace_filter_macros.svh]
// Assertion macros shared by the filter's modules.
`ifndef UTF8_RUN_REPLACE_FILTER_MACROS_SVH
`define UTF8_RUN_REPLACE_FILTER_MACROS_SVH

// Implication checked on every clock, masked while reset is held.
`define UTF8RR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Plain condition that holds on every clock outside reset.
`define UTF8RR_ASSERT_ALWAYS(lbl, cond, msg) \
  `UTF8RR_ASSERT(lbl, (1'b1 |-> (cond)), msg)

`endif

[rtl/utf8rr_pkg.sv]
// Types and constants shared by the UTF-8 run replacement filter.
package utf8rr_pkg;

  localparam int CP_W              = 21;
  localparam int CNT_W             = 24;
  localparam int RUNS_W            = 16;
  localparam int RLEN_W            = 4;
  localparam int TEXT_W            = 64;
  localparam int REPLACE_MAX_BYTES = 8;
  localparam int CFG_ADDR_W        = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int IN_TDATA_W        = 8;
  localparam int OUT_TDATA_W       = 48;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [RLEN_W-1:0] REP_MAX   = RLEN_W'(REPLACE_MAX_BYTES);

  // Register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] CFG_MATCH_FIRST = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MATCH_LAST  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REP_TEXT    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_REP_LEN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_REPS    = 3'd4;

  typedef struct packed {
    logic [CP_W-1:0]   match_first;
    logic [CP_W-1:0]   match_last;
    logic [TEXT_W-1:0] rep_text;
    logic [RLEN_W-1:0] rep_len;
    logic [RUNS_W-1:0] max_reps;
  } cfg_t;

  // Everything one input word leaves for the output side
  typedef struct packed {
    logic              pass;    // value holds a passed code point
    logic [CP_W-1:0]   value;
    logic [RLEN_W-1:0] n_val;   // code point or replacement bytes, 0..8
    logic              eot;     // end marker follows
    logic [CNT_W-1:0]  total;
  } job_t;

endpackage

[rtl/utf8rr_cfg_regs.sv]
// Configuration register file for the filter.
module utf8rr_cfg_regs
  import utf8rr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MATCH_FIRST: cfg_d.match_first = cfg_wdata_i[CP_W-1:0];
        CFG_MATCH_LAST:  cfg_d.match_last  = cfg_wdata_i[CP_W-1:0];
        CFG_REP_TEXT:    cfg_d.rep_text    = cfg_wdata_i[TEXT_W-1:0];
        CFG_REP_LEN:     cfg_d.rep_len     = cfg_wdata_i[RLEN_W-1:0];
        CFG_MAX_REPS:    cfg_d.max_reps    = cfg_wdata_i[RUNS_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_first <= CP_W'(97);
      cfg_q.match_last  <= CP_W'(97);
      cfg_q.rep_text    <= TEXT_W'(64'h775A68);
      cfg_q.rep_len     <= RLEN_W'(3);
      cfg_q.max_reps    <= RUNS_W'(3);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/utf8rr_decoder.sv]
// UTF-8 decode, match run tracking and emitted count per input word.
module utf8rr_decoder
  import utf8rr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  accept_i,
  input  logic [IN_TDATA_W-1:0] byte_i,
  input  logic                  eot_i,
  output logic                  job_valid_o,
  output job_t                  job_o
);

  `include "utf8_run_replace_filter_macros.svh"

  logic [CP_W-1:0]   acc_q, acc_d;
  logic [1:0]        rem_q, rem_d;
  logic              run_q, run_d;
  logic [RUNS_W-1:0] runs_q, runs_d;
  logic              halt_q, halt_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              have_cp;
  logic [CP_W-1:0]   cp;
  logic              match;
  logic              pass;
  logic [RLEN_W-1:0] n_rep;
  logic [RLEN_W-1:0] n_val;
  logic [CNT_W:0]    cnt_sum;

  always_comb begin
    acc_d   = acc_q;
    rem_d   = rem_q;
    halt_d  = halt_q;
    have_cp = 1'b0;
    cp      = '0;
    if (!halt_q) begin
      if (rem_q != 2'd0) begin
        // continuation: top bits not checked
        acc_d = {acc_q[CP_W-7:0], byte_i[5:0]};
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          have_cp = 1'b1;
          cp      = acc_d;
        end
      end else if (!byte_i[7]) begin
        have_cp = 1'b1;
        cp      = {{(CP_W-8){1'b0}}, byte_i};
      end else if (byte_i[7:5] == 3'b110) begin
        acc_d = {{(CP_W-5){1'b0}}, byte_i[4:0]};
        rem_d = 2'd1;
      end else if (byte_i[7:4] == 4'b1110) begin
        acc_d = {{(CP_W-4){1'b0}}, byte_i[3:0]};
        rem_d = 2'd2;
      end else if (byte_i[7:3] == 5'b11110) begin
        acc_d = {{(CP_W-3){1'b0}}, byte_i[2:0]};
        rem_d = 2'd3;
      end else begin
        halt_d = 1'b1;
      end
    end
  end

  assign match = (cp >= cfg_i.match_first) && (cp <= cfg_i.match_last);

  always_comb begin
    run_d  = run_q;
    runs_d = runs_q;
    pass   = 1'b0;
    n_rep  = '0;
    if (have_cp) begin
      if (match) begin
        if (!run_q && (runs_q < cfg_i.max_reps)) begin
          run_d  = 1'b1;
          runs_d = runs_q + RUNS_W'(1);
          n_rep  = (cfg_i.rep_len > REP_MAX) ? REP_MAX : cfg_i.rep_len;
        end
      end else begin
        run_d = 1'b0;
        pass  = 1'b1;
      end
    end
  end

  assign n_val   = n_rep + {{(RLEN_W-1){1'b0}}, pass};
  assign cnt_sum = {1'b0, cnt_q} + (CNT_W+1)'(n_val);
  assign cnt_d   = cnt_sum[CNT_W] ? COUNT_MAX : cnt_sum[CNT_W-1:0];

  always_comb begin
    job_o.pass  = pass;
    job_o.value = cp;
    job_o.n_val = n_val;
    job_o.eot   = eot_i;
    job_o.total = cnt_d;
  end

  assign job_valid_o = accept_i && ((n_val != '0) || eot_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      run_q  <= 1'b0;
      runs_q <= '0;
      halt_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      if (eot_i) begin
        acc_q  <= '0;
        rem_q  <= '0;
        run_q  <= 1'b0;
        runs_q <= '0;
        halt_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        acc_q  <= acc_d;
        rem_q  <= rem_d;
        run_q  <= run_d;
        runs_q <= runs_d;
        halt_q <= halt_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  `UTF8RR_ASSERT(a_eot_clears, (accept_i && eot_i) |=> (!halt_q && rem_q == 2'd0 && cnt_q == '0), "state not cleared at end of text")
  `UTF8RR_ASSERT(a_halt_no_job, (halt_q && accept_i && !eot_i) |-> !job_valid_o, "output while halted")
  `UTF8RR_ASSERT_ALWAYS(a_halt_idle, !(halt_q && rem_q != 2'd0), "halted inside a sequence")

endmodule

[rtl/utf8rr_emitter.sv]
// Holds one decoded job and plays out its result words in order.
module utf8rr_emitter
  import utf8rr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [TEXT_W-1:0]      rep_text_i,
  input  logic                   job_valid_i,
  input  job_t                   job_i,
  output logic                   free_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  `include "utf8_run_replace_filter_macros.svh"

  job_t              job_q;
  logic              valid_q;
  logic [RLEN_W-1:0] idx_q;
  logic [RLEN_W-1:0] n_res;
  logic              is_val;
  logic              last;
  logic              take;
  logic [CP_W-1:0]   value;
  logic [7:0]        rep_byte;

  assign n_res    = job_q.n_val + {{(RLEN_W-1){1'b0}}, job_q.eot};
  assign is_val   = idx_q < job_q.n_val;
  assign last     = idx_q == (n_res - RLEN_W'(1));
  assign rep_byte = rep_text_i[idx_q[2:0]*8 +: 8];
  assign value    = job_q.pass ? job_q.value : {{(CP_W-8){1'b0}}, rep_byte};
  assign take     = valid_q && m_axis_tready;
  assign free_o   = !valid_q || (take && last);

  // tdata: out_value [20:0], total_length [44:21], zero pad
  always_comb begin
    m_axis_tdata = '0;
    if (is_val) begin
      m_axis_tdata[CP_W-1:0] = value;
    end else begin
      m_axis_tdata[CP_W+CNT_W-1:CP_W] = job_q.total;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = !is_val;
  assign m_axis_tlast  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (free_o) begin
      valid_q <= job_valid_i;
      idx_q   <= '0;
    end else if (take) begin
      idx_q <= idx_q + RLEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && job_valid_i) begin
      job_q <= job_i;
    end
  end

  `UTF8RR_ASSERT(a_idx_range, valid_q |-> (idx_q < n_res), "word index past end of job")
  `UTF8RR_ASSERT(a_step, (take && !last) |=> (valid_q && idx_q == $past(idx_q) + RLEN_W'(1)), "job word skipped")
  `UTF8RR_ASSERT(a_marker_last, (valid_q && m_axis_tuser) |-> m_axis_tlast, "end marker not final word")

endmodule

[rtl/utf8_run_replace_filter.sv]
// UTF-8 decoder that replaces match runs and closes each text with a length marker.
// A word is accepted into the decoder and its first result shows in the cycle after.
// Throughput: one input word per cycle while each word yields at most one result and the
// output is ready; a word with more (up to 9) stalls the input behind the single job register.
// Reset: rst_ni is asynchronous, active low; registers return to defaults, state to zero.
module utf8_run_replace_filter
  import utf8rr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // text_byte [7:0]
  input  logic                   s_axis_tlast,  // end_of_text
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_value [20:0], total_length [44:21]
  output logic                   m_axis_tuser,  // is_end_marker
  output logic                   m_axis_tlast   // last_of_run
);

  cfg_t cfg;
  job_t job;
  logic job_valid;
  logic free;
  logic accept;

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  utf8rr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  utf8rr_decoder u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .eot_i       (s_axis_tlast),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  utf8rr_emitter u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rep_text_i    (cfg.rep_text),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
